>>> src/ssc_pkg.sv
// Package for the steering and speed slew controller.
// Holds field widths, register indexes, reset values, control constants and the exp table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam int ErrW     = 9;
  localparam int HeadW    = 8;
  localparam int GainW    = 10;
  localparam int SteerW   = 8;
  localparam int SpeedW   = 11;
  localparam int SlewW    = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  localparam int ExpDepth = 256;
  localparam int ExpIdxW  = $clog2(ExpDepth);
  localparam int ExpW     = 16;
  localparam logic [63:0] ExpStepQ32 = 64'd4209921245;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainTurn      = 3'd0,
    CfgGainStraight  = 3'd1,
    CfgSteerMin      = 3'd2,
    CfgSteerMax      = 3'd3,
    CfgLimitTurn     = 3'd4,
    CfgLimitStraight = 3'd5,
    CfgSlewStep      = 3'd6
  } cfg_idx_e;

  localparam logic [GainW-1:0]         GainTurnRst      = 10'd320;
  localparam logic [GainW-1:0]         GainStraightRst  = 10'd77;
  localparam logic [SteerW-1:0]        SteerMinRst      = 8'd20;
  localparam logic [SteerW-1:0]        SteerMaxRst      = 8'd160;
  localparam logic signed [SpeedW-1:0] LimitTurnRst     = -11'sd600;
  localparam logic signed [SpeedW-1:0] LimitStraightRst = -11'sd700;
  localparam logic [SlewW-1:0]         SlewStepRst      = 4'd3;
  localparam logic [HeadW-1:0]         HeadingRst       = 8'd98;

  localparam logic [HeadW-1:0] BandLo = 8'd90;
  localparam logic [HeadW-1:0] BandHi = 8'd110;

  localparam logic signed [12:0] SpeedHyst   = 13'sd9;
  localparam logic signed [12:0] SpeedDec    = 13'sd2;
  localparam logic signed [12:0] SpeedInc    = 13'sd5;
  localparam logic signed [12:0] SpeedSatMax = 13'sd1023;
  localparam logic signed [12:0] SpeedSatMin = -13'sd1023;

  typedef logic [ExpDepth-1:0][ExpW-1:0] exp_rom_t;

  // Entry k is exp(-0.02 k) in Q0.16, built from a rounded Q0.32 recurrence.
  function automatic exp_rom_t build_exp_rom();
    logic [63:0] acc;
    logic [63:0] q;
    exp_rom_t    rom;
    acc = 64'd1 << 32;
    for (int k = 0; k < ExpDepth; k++) begin
      q = (acc + 64'd32768) >> 16;
      rom[k] = (q > 64'd65535) ? 16'hFFFF : q[ExpW-1:0];
      acc = (acc * ExpStepQ32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

`default_nettype wire

>>> src/ssc_in_if.sv
// Input channel carrying one lane measurement per transaction.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              lane_found;
  logic signed [ssc_pkg::ErrW-1:0]   lateral_error;
  logic        [ssc_pkg::HeadW-1:0]  heading;

  modport source (output valid, lane_found, lateral_error, heading, input ready);
  modport sink   (input valid, lane_found, lateral_error, heading, output ready);
endinterface

`default_nettype wire

>>> src/ssc_out_if.sv
// Output channel carrying one steering and speed command per transaction.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssc_out_if;
  logic                              valid;
  logic                              ready;
  logic        [ssc_pkg::SteerW-1:0] steering;
  logic signed [ssc_pkg::SpeedW-1:0] speed;
  logic signed [ssc_pkg::SpeedW-1:0] speed_limit;

  modport source (output valid, steering, speed, speed_limit, input ready);
  modport sink   (input valid, steering, speed, speed_limit, output ready);
endinterface

`default_nettype wire

>>> src/steering_speed_slew_controller.sv
// Top level of the steering and speed slew controller.
// Depends on ssc_pkg, ssc_in_if and ssc_out_if.
//
// Usage: each input transaction carries one frame's lane measurement (found flag,
// lateral error, heading). Each one yields exactly one output transaction with the
// slew-limited steering command, the ramped speed and the speed limit used.
// The measurement is captured in an input register; the compute stage forms the
// steering target, slew, clamp, exp-scaled speed limit and speed ramp and, unless
// the output stalls, updates the controller state and loads the result register.
// One transaction is accepted per cycle while the receiver keeps ready high; the
// rate is set by the single compute stage between the two registers, which also
// owns the feedback state, so every frame sees the previous frame's state. When
// the receiver stalls, the result register holds and the input register can still
// take one more transaction before ready drops. Configuration registers are
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i; unknown indexes are
// ignored. The user must write them only while the block is idle; the block does
// not enforce this. Reset restores the register defaults, clears the held error,
// previous error, steering and speed, and sets the held heading to straight ahead.
`timescale 1ns / 1ps
`default_nettype none

module steering_speed_slew_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ssc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  ssc_in_if.sink                               in_i,
  ssc_out_if.source                            out_o
);
  import ssc_pkg::*;

  logic        [GainW-1:0]  gain_turn_q, gain_straight_q;
  logic        [SteerW-1:0] steer_min_q, steer_max_q;
  logic signed [SpeedW-1:0] limit_turn_q, limit_straight_q;
  logic        [SlewW-1:0]  slew_step_q;

  logic                     s1_valid_q;
  logic                     s1_found_q;
  logic signed [ErrW-1:0]   s1_err_q;
  logic        [HeadW-1:0]  s1_head_q;

  logic signed [ErrW-1:0]   held_error_q, held_error_d;
  logic signed [ErrW-1:0]   prev_error_q;
  logic        [HeadW-1:0]  held_heading_q, held_heading_d;
  logic        [SteerW-1:0] steer_q, steer_d;
  logic signed [SpeedW-1:0] speed_q, speed_d;
  logic signed [SpeedW-1:0] limit_d;

  logic                     out_valid_q;
  logic        [SteerW-1:0] out_steer_q;
  logic signed [SpeedW-1:0] out_speed_q, out_limit_q;

  logic s1_advance;
  logic in_take;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_turn_q      <= GainTurnRst;
      gain_straight_q  <= GainStraightRst;
      steer_min_q      <= SteerMinRst;
      steer_max_q      <= SteerMaxRst;
      limit_turn_q     <= LimitTurnRst;
      limit_straight_q <= LimitStraightRst;
      slew_step_q      <= SlewStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGainTurn:      gain_turn_q      <= cfg_wdata_i[GainW-1:0];
        CfgGainStraight:  gain_straight_q  <= cfg_wdata_i[GainW-1:0];
        CfgSteerMin:      steer_min_q      <= cfg_wdata_i[SteerW-1:0];
        CfgSteerMax:      steer_max_q      <= cfg_wdata_i[SteerW-1:0];
        CfgLimitTurn:     limit_turn_q     <= $signed(cfg_wdata_i[SpeedW-1:0]);
        CfgLimitStraight: limit_straight_q <= $signed(cfg_wdata_i[SpeedW-1:0]);
        CfgSlewStep:      slew_step_q      <= cfg_wdata_i[SlewW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_found_q <= in_i.lane_found;
      s1_err_q   <= in_i.lateral_error;
      s1_head_q  <= in_i.heading;
    end
  end

  logic                     straight;
  logic        [GainW-1:0]  gain;
  logic signed [SpeedW-1:0] mode_limit;
  logic signed [19:0]       steer_prod, steer_prod_adj;
  logic signed [11:0]       gain_term;
  logic signed [12:0]       target, steer_ext, step_ext, slewed;
  logic signed [12:0]       steer_min_ext, steer_max_ext;
  logic        [ErrW-1:0]   err_mag;
  logic        [ExpIdxW-1:0] exp_idx;
  logic        [ExpW-1:0]   exp_val;
  logic signed [27:0]       lim_prod, lim_prod_adj;
  logic signed [12:0]       lim_ext, spd;

  always_comb begin
    held_error_d   = s1_found_q ? s1_err_q  : held_error_q;
    held_heading_d = s1_found_q ? s1_head_q : held_heading_q;

    straight   = (held_heading_d >= BandLo) && (held_heading_d <= BandHi);
    gain       = straight ? gain_straight_q : gain_turn_q;
    mode_limit = straight ? limit_straight_q : limit_turn_q;

    // Truncating division by 256 toward zero.
    steer_prod     = 20'($signed({1'b0, gain})) * 20'(held_error_d);
    steer_prod_adj = steer_prod + $signed({12'd0, {8{steer_prod[19]}}});
    gain_term      = steer_prod_adj[19:8];
    target = 13'(gain_term) + $signed({5'd0, held_heading_d})
           + (13'(held_error_d) - 13'(prev_error_q));

    steer_ext     = $signed({5'd0, steer_q});
    step_ext      = $signed({9'd0, slew_step_q});
    steer_min_ext = $signed({5'd0, steer_min_q});
    steer_max_ext = $signed({5'd0, steer_max_q});
    if (target > steer_ext + step_ext) begin
      slewed = steer_ext + step_ext;
    end else if (target < steer_ext - step_ext) begin
      slewed = steer_ext - step_ext;
    end else begin
      slewed = steer_ext;
    end
    if (slewed > steer_max_ext) begin
      slewed = steer_max_ext;
    end else if (slewed < steer_min_ext) begin
      slewed = steer_min_ext;
    end
    steer_d = slewed[SteerW-1:0];

    err_mag = held_error_d[ErrW-1] ? ErrW'(-held_error_d) : ErrW'(held_error_d);
    exp_idx = (int'(err_mag) > ExpDepth - 1) ? ExpIdxW'(ExpDepth - 1) : ExpIdxW'(err_mag);
    exp_val = ExpRom[exp_idx];

    // Truncating division by 65536 toward zero.
    lim_prod     = 28'(mode_limit) * 28'($signed({1'b0, exp_val}));
    lim_prod_adj = lim_prod + $signed({12'd0, {16{lim_prod[27]}}});
    limit_d      = lim_prod_adj[26:16];
    lim_ext      = 13'($signed(lim_prod_adj[27:16]));

    spd = 13'(speed_q);
    if (spd > lim_ext + SpeedHyst) begin
      spd = spd - SpeedDec;
    end else if (spd <= lim_ext) begin
      spd = spd + SpeedInc;
    end
    if (spd > SpeedSatMax) begin
      spd = SpeedSatMax;
    end
    if (spd < SpeedSatMin) begin
      spd = SpeedSatMin;
    end
    speed_d = spd[SpeedW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_error_q   <= '0;
      prev_error_q   <= '0;
      held_heading_q <= HeadingRst;
      steer_q        <= '0;
      speed_q        <= '0;
    end else if (s1_advance) begin
      held_error_q   <= held_error_d;
      prev_error_q   <= held_error_d;
      held_heading_q <= held_heading_d;
      steer_q        <= steer_d;
      speed_q        <= speed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_steer_q <= steer_d;
      out_speed_q <= speed_d;
      out_limit_q <= limit_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.steering    = out_steer_q;
  assign out_o.speed       = out_speed_q;
  assign out_o.speed_limit = out_limit_q;

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for steering_speed_slew_controller: directed frames, configuration
// extremes, random lane runs and speed saturation, checked against a cycle-free predictor.
// Depends on ssc_pkg, ssc_in_if, ssc_out_if and the controller top level.
`timescale 1ns / 1ps

module tb;
  import ssc_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int DrainCycles  = 8;
  localparam int MaxPrinted   = 100;
  localparam int StraightLo   = 90;
  localparam int StraightHi   = 110;
  localparam int StraightHead = 98;
  localparam int SpeedCeil    = 1023;
  localparam int SpeedFloor   = -1023;
  localparam int OverLimitHyst = 9;
  localparam int SpeedDown    = 2;
  localparam int SpeedUp      = 5;
  localparam longint unsigned ExpDecayQ32 = 64'd4209921245;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd7;

  typedef struct {
    logic                     lane_found;
    logic signed [ErrW-1:0]   lateral_error;
    logic        [HeadW-1:0]  heading;
  } frame_t;

  typedef struct {
    logic        [SteerW-1:0] steering;
    logic signed [SpeedW-1:0] speed;
    logic signed [SpeedW-1:0] speed_limit;
  } command_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  steering_speed_slew_controller DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic        [GainW-1:0]  turn_gain;
  logic        [GainW-1:0]  straight_gain;
  logic        [SteerW-1:0] steer_floor;
  logic        [SteerW-1:0] steer_ceil;
  logic signed [SpeedW-1:0] turn_speed_limit;
  logic signed [SpeedW-1:0] straight_speed_limit;
  logic        [SlewW-1:0]  slew_per_frame;

  logic signed [ErrW-1:0]   held_err;
  logic signed [ErrW-1:0]   last_err;
  logic        [HeadW-1:0]  held_head;
  logic        [SteerW-1:0] steer_state;
  logic signed [SpeedW-1:0] speed_state;

  int              exp_q16 [ExpDepth];
  longint unsigned exp_acc;
  longint unsigned exp_q;

  command_t expected_cmds [$];
  int       mismatches;
  int       cycle_count;
  bit       idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("steering_speed_slew_controller test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts while idling is enabled.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatches < MaxPrinted)
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_commands
    command_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        note_mismatch("command with nothing pending, steering", int'(out_ch.steering), 0);
      end else begin
        want = expected_cmds.pop_front();
        if (out_ch.steering !== want.steering)
          note_mismatch("steering", int'(out_ch.steering), int'(want.steering));
        if (out_ch.speed !== want.speed)
          note_mismatch("speed", int'(out_ch.speed), int'(want.speed));
        if (out_ch.speed_limit !== want.speed_limit)
          note_mismatch("speed_limit", int'(out_ch.speed_limit), int'(want.speed_limit));
      end
    end
  end

  function automatic command_t advance_controller(input frame_t f);
    command_t cmd;
    int       e, h, g, mode_lim, target, step, steer, lo, hi, mag, lim, spd;
    longint   prod;
    if (f.lane_found) begin
      held_err  = f.lateral_error;
      held_head = f.heading;
    end
    e = held_err;
    h = held_head;
    if (h >= StraightLo && h <= StraightHi) begin
      g        = straight_gain;
      mode_lim = straight_speed_limit;
    end else begin
      g        = turn_gain;
      mode_lim = turn_speed_limit;
    end
    target   = (g * e) / 256 + h + (e - int'(last_err));
    last_err = held_err;

    step  = slew_per_frame;
    steer = steer_state;
    lo    = steer_floor;
    hi    = steer_ceil;
    if (target > steer + step) steer = steer + step;
    else if (target < steer - step) steer = steer - step;
    if (steer > hi) steer = hi;
    else if (steer < lo) steer = lo;
    steer_state = steer[SteerW-1:0];

    mag = (e < 0) ? -e : e;
    if (mag > ExpDepth - 1) mag = ExpDepth - 1;
    prod = longint'(mode_lim) * longint'(exp_q16[mag]);
    lim  = int'(prod / 64'sd65536);

    spd = speed_state;
    if (spd > lim + OverLimitHyst) spd = spd - SpeedDown;
    else if (spd <= lim) spd = spd + SpeedUp;
    if (spd > SpeedCeil) spd = SpeedCeil;
    if (spd < SpeedFloor) spd = SpeedFloor;
    speed_state = spd[SpeedW-1:0];

    cmd.steering    = steer_state;
    cmd.speed       = speed_state;
    cmd.speed_limit = lim[SpeedW-1:0];
    return cmd;
  endfunction

  function automatic frame_t make_frame(input int found, input int err, input int head);
    frame_t f;
    f.lane_found    = (found != 0);
    f.lateral_error = err[ErrW-1:0];
    f.heading       = head[HeadW-1:0];
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.lane_found    <= f.lane_found;
    in_ch.lateral_error <= f.lateral_error;
    in_ch.heading       <= f.heading;
    do @(posedge clk); while (!in_ch.ready);
    expected_cmds.insert(expected_cmds.size(), advance_controller(f));
  endtask

  task automatic drain_commands();
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgGainTurn:      turn_gain            = data[GainW-1:0];
      CfgGainStraight:  straight_gain        = data[GainW-1:0];
      CfgSteerMin:      steer_floor          = data[SteerW-1:0];
      CfgSteerMax:      steer_ceil           = data[SteerW-1:0];
      CfgLimitTurn:     turn_speed_limit     = data[SpeedW-1:0];
      CfgLimitStraight: straight_speed_limit = data[SpeedW-1:0];
      CfgSlewStep:      slew_per_frame       = data[SlewW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_random_config();
    int v;
    write_reg(CfgGainTurn, CfgDataW'($urandom_range(0, 1023)));
    write_reg(CfgGainStraight, CfgDataW'($urandom_range(0, 1023)));
    write_reg(CfgSteerMin, CfgDataW'($urandom_range(0, 120)));
    write_reg(CfgSteerMax, CfgDataW'($urandom_range(100, 255)));
    v = ($urandom_range(0, 5) == 0) ? int'($urandom) : -int'($urandom_range(0, 1000));
    write_reg(CfgLimitTurn, v[CfgDataW-1:0]);
    v = ($urandom_range(0, 5) == 0) ? int'($urandom) : -int'($urandom_range(0, 1000));
    write_reg(CfgLimitStraight, v[CfgDataW-1:0]);
    write_reg(CfgSlewStep, CfgDataW'($urandom_range(0, 15)));
  endtask

  task automatic test_reset_values();
    send_frame(make_frame(1, 10, 98));
    send_frame(make_frame(1, -20, 98));
    send_frame(make_frame(0, 0, 0));
    send_frame(make_frame(1, 0, 98));
    send_frame(make_frame(1, 50, 200));
  endtask

  // Field extremes, the band edges and back-to-back lost lanes.
  task automatic test_field_extremes();
    send_frame(make_frame(1, -256, 98));
    send_frame(make_frame(1, 255, 98));
    send_frame(make_frame(1, -255, 0));
    send_frame(make_frame(1, 0, 255));
    send_frame(make_frame(1, 0, 89));
    send_frame(make_frame(1, 0, 90));
    send_frame(make_frame(1, 0, 110));
    send_frame(make_frame(1, 0, 111));
    send_frame(make_frame(0, 0, 0));
    send_frame(make_frame(0, -1, 255));
    send_frame(make_frame(1, 100, 111));
    send_frame(make_frame(1, -100, 89));
  endtask

  // Largest gains and slew, then zero gains, crossed steer limits and extreme speed limits.
  task automatic test_config_extremes();
    drain_commands();
    write_reg(CfgGainTurn, 11'd1023);
    write_reg(CfgGainStraight, 11'd1023);
    write_reg(CfgSlewStep, 11'd15);
    write_reg(CfgSteerMin, 11'd0);
    write_reg(CfgSteerMax, 11'd255);
    write_reg(CfgLimitTurn, 11'h418);
    write_reg(CfgLimitStraight, 11'h418);
    send_frame(make_frame(1, 255, 50));
    send_frame(make_frame(1, -256, 100));
    drain_commands();
    write_reg(CfgGainTurn, 11'd0);
    write_reg(CfgGainStraight, 11'd0);
    write_reg(CfgSlewStep, 11'd0);
    write_reg(CfgSteerMin, 11'd200);
    write_reg(CfgSteerMax, 11'd50);
    write_reg(CfgLimitTurn, 11'h400);
    write_reg(CfgLimitStraight, 11'h3FF);
    write_reg(CfgSpareIdx, 11'h7FF);
    send_frame(make_frame(1, 5, 98));
    send_frame(make_frame(1, -5, 200));
    send_frame(make_frame(1, 255, 98));
    send_frame(make_frame(1, -256, 0));
    drain_commands();
    write_reg(CfgSteerMax, 11'd0);
    write_reg(CfgSteerMin, 11'd255);
    write_reg(CfgSlewStep, 11'd15);
    write_reg(CfgLimitStraight, 11'd0);
    send_frame(make_frame(1, 3, 100));
    send_frame(make_frame(1, -3, 100));
  endtask

  // Runs of similar measurements with jitter and lost lanes, mixed with fully random frames.
  task automatic test_random_phases();
    frame_t f;
    int     sent, run_len, base_err, base_head, e, h;
    for (int phase = 0; phase < 8; phase++) begin
      drain_commands();
      if (phase == 0) begin
        write_reg(CfgGainTurn, 11'd1023);
        write_reg(CfgGainStraight, 11'd1023);
        write_reg(CfgSteerMin, 11'd0);
        write_reg(CfgSteerMax, 11'd255);
        write_reg(CfgLimitTurn, 11'h418);
        write_reg(CfgLimitStraight, 11'h418);
        write_reg(CfgSlewStep, 11'd15);
      end else if (phase == 1) begin
        write_reg(CfgGainTurn, 11'd0);
        write_reg(CfgGainStraight, 11'd0);
        write_reg(CfgSteerMin, 11'd0);
        write_reg(CfgSteerMax, 11'd0);
        write_reg(CfgLimitTurn, 11'd0);
        write_reg(CfgLimitStraight, 11'd0);
        write_reg(CfgSlewStep, 11'd0);
      end else begin
        load_random_config();
      end
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(0, 9) < 7) begin
          base_err  = $urandom_range(0, 1) ? int'($urandom_range(0, 511)) - 256
                                           : int'($urandom_range(0, 40)) - 20;
          base_head = $urandom_range(0, 1) ? int'($urandom_range(85, 115))
                                           : int'($urandom_range(0, 255));
          run_len   = $urandom_range(1, 30);
          for (int i = 0; i < run_len && sent < 75; i++) begin
            e = base_err + int'($urandom_range(0, 8)) - 4;
            h = base_head + int'($urandom_range(0, 6)) - 3;
            if (e < -256) e = -256;
            if (e > 255) e = 255;
            if (h < 0) h = 0;
            if (h > 255) h = 255;
            send_frame(make_frame(int'($urandom_range(0, 9) != 0), e, h));
            sent++;
          end
        end else begin
          f.lane_found    = 1'($urandom_range(0, 1));
          f.lateral_error = ErrW'($urandom);
          f.heading       = HeadW'($urandom);
          send_frame(f);
          sent++;
        end
      end
    end
  endtask

  // Positive limits with a near-zero error ramp the speed up into its upper saturation.
  task automatic test_speed_saturation();
    drain_commands();
    idle_on = 1'b0;
    write_reg(CfgLimitTurn, 11'h3FF);
    write_reg(CfgLimitStraight, 11'h3FF);
    write_reg(CfgSteerMin, 11'd20);
    write_reg(CfgSteerMax, 11'd160);
    write_reg(CfgSlewStep, CfgDataW'($urandom_range(1, 15)));
    for (int i = 0; i < 350; i++)
      send_frame(make_frame(int'($urandom_range(0, 7) != 0), int'($urandom_range(0, 4)) - 2,
                            int'($urandom_range(0, 255))));
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.lane_found    <= 1'b0;
    in_ch.lateral_error <= '0;
    in_ch.heading       <= '0;
    mismatches  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;

    exp_acc = 64'd1 << 32;
    for (int k = 0; k < ExpDepth; k++) begin
      exp_q      = (exp_acc + 64'd32768) >> 16;
      exp_q16[k] = (exp_q > 64'd65535) ? 65535 : int'(exp_q);
      exp_acc    = (exp_acc * ExpDecayQ32 + (64'd1 << 31)) >> 32;
    end

    turn_gain            = 10'd320;
    straight_gain        = 10'd77;
    steer_floor          = 8'd20;
    steer_ceil           = 8'd160;
    turn_speed_limit     = -11'sd600;
    straight_speed_limit = -11'sd700;
    slew_per_frame       = 4'd3;
    held_err             = '0;
    last_err             = '0;
    held_head            = HeadW'(StraightHead);
    steer_state          = '0;
    speed_state          = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_config_extremes();
    test_random_phases();
    test_speed_saturation();
    drain_commands();

    if (mismatches == 0) begin
      $display("steering_speed_slew_controller test passed");
    end else begin
      $display("steering_speed_slew_controller test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ssc_pkg.sv
src/ssc_in_if.sv
src/ssc_out_if.sv
src/steering_speed_slew_controller.sv
bench/tb.sv
